// ===== rtl/gyi_pkg.sv =====
// ---------------------------------------------------------------------------
// gyi_pkg: shared types and constants for the gyro yaw integrator
// Field widths, register reset values, control state encoding and the
// command and status bundles passed between controller and datapath.
// ---------------------------------------------------------------------------
package gyi_pkg;

   localparam int CFG_W       = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int RATE_W      = 16;
   localparam int TICK_W      = 32;
   localparam int CALIB_SUM_W = 26;
   localparam int BIAS_W      = 26;
   localparam int DELTA_W     = BIAS_W + 1;
   localparam int PROD_W      = DELTA_W + CFG_W + 1;
   localparam int DIV_STEPS   = CALIB_SUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [CFG_W-1:0] CALIB_SAMPLES_RESET = 10'd300;
   localparam logic [CFG_W-1:0] MAX_DT_RESET        = 10'd200;
   localparam logic [CFG_W-1:0] DEFAULT_DT_RESET    = 10'd20;

   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DT        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_DT    = 2'd2;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_EXEC     = 7'b0000010,
      ST_DIV_LOAD = 7'b0000100,
      ST_DIV_RUN  = 7'b0001000,
      ST_MUL      = 7'b0010000,
      ST_ACC      = 7'b0100000,
      ST_OUT      = 7'b1000000
   } gyi_state_type;

   typedef struct packed {
      logic capture;
      logic restart;
      logic calib_add;
      logic div_start;
      logic bias_load;
      logic step_prep;
      logic step_mul;
      logic step_acc;
      logic out_load;
   } gyi_cmd_type;

   typedef struct packed {
      logic op_restart;
      logic is_ready;
      logic calib_last;
      logic div_done;
   } gyi_status_type;

endpackage

// ===== rtl/gyi_div.sv =====
// ---------------------------------------------------------------------------
// gyi_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, for the bias average.
// ---------------------------------------------------------------------------
module gyi_div import gyi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [CALIB_SUM_W-1:0] dividend,
   input  logic [CFG_W-1:0]       divisor,
   output logic [CALIB_SUM_W-1:0] quotient,
   output logic                   done
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CALIB_SUM_W-1:0] quo_ff, quo_in;
   logic [CFG_W-1:0]       rem_ff, rem_in;
   logic [CFG_W-1:0]       den_ff, den_in;
   logic [CFG_W:0]         shifted;
   logic [CFG_W:0]         diff;
   logic                   ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[CALIB_SUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
         quo_in = {quo_ff[CALIB_SUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/gyi_ctrl.sv =====
// ---------------------------------------------------------------------------
// gyi_ctrl: sequencing controller
// Takes one transaction at a time, steps the datapath through a restart,
// calibration, bias division or integration, and owns the result valid flag.
// ---------------------------------------------------------------------------
module gyi_ctrl import gyi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  gyi_status_type status,
   output gyi_cmd_type    cmd
);

   gyi_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.op_restart) begin
               cmd.restart = 1'b1;
               state_in    = ST_OUT;
            end else if (!status.is_ready) begin
               cmd.calib_add = 1'b1;
               state_in      = status.calib_last ? ST_DIV_LOAD : ST_OUT;
            end else begin
               cmd.step_prep = 1'b1;
               state_in      = ST_MUL;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               cmd.bias_load = 1'b1;
               state_in      = ST_OUT;
            end
         end
         ST_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.step_acc = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/gyi_dp.sv =====
// ---------------------------------------------------------------------------
// gyi_dp: yaw integrator datapath
// Configuration registers, calibration sum and count, bias, tick tracking,
// rate times dt product, saturating yaw accumulator and output register.
// ---------------------------------------------------------------------------
module gyi_dp import gyi_pkg::*; #(
   parameter int YAW_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gyi_cmd_type                 cmd,
   output gyi_status_type              status,
   input  logic                        req_opcode,
   input  logic signed [RATE_W-1:0]    req_gyro_rate,
   input  logic [TICK_W-1:0]           req_tick_ms,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_wdata,
   output logic signed [YAW_WIDTH-1:0] rsp_yaw_angle,
   output logic                        rsp_ready_res
);

   localparam int SUM_W = ((YAW_WIDTH > PROD_W) ? YAW_WIDTH : PROD_W) + 1;

   // configuration
   logic [CFG_W-1:0] calib_samples_ff, calib_samples_in;
   logic [CFG_W-1:0] max_dt_ff, max_dt_in;
   logic [CFG_W-1:0] default_dt_ff, default_dt_in;

   // integrator state
   logic signed [YAW_WIDTH-1:0]   yaw_accum_ff, yaw_accum_in;
   logic signed [BIAS_W-1:0]      bias_ff, bias_in;
   logic signed [CALIB_SUM_W-1:0] calib_sum_ff, calib_sum_in;
   logic [CFG_W-1:0]              calib_count_ff, calib_count_in;
   logic [TICK_W-1:0]             last_tick_ff, last_tick_in;
   logic                          is_ready_ff, is_ready_in;

   // captured transaction and working registers
   logic                        op_ff;
   logic signed [RATE_W-1:0]    rate_ff;
   logic [TICK_W-1:0]           tick_ff;
   logic [CFG_W-1:0]            dt_ff, dt_in;
   logic signed [DELTA_W-1:0]   delta_ff, delta_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [YAW_WIDTH-1:0] rsp_yaw_ff;
   logic                        rsp_ready_ff;

   logic [CFG_W-1:0]              n_eff;
   logic [CFG_W-1:0]              count_next;
   logic [CALIB_SUM_W-1:0]        sum_mag;
   logic [CALIB_SUM_W-1:0]        dividend;
   logic [CALIB_SUM_W-1:0]        quotient;
   logic signed [CALIB_SUM_W-1:0] quo_s;
   logic                          div_done;
   logic [TICK_W-1:0]             tick_gap;
   logic                          gap_bad;
   logic signed [SUM_W-1:0]       yaw_sum;
   logic [SUM_W-YAW_WIDTH:0]      yaw_upper;

   assign n_eff      = (calib_samples_ff == '0) ? CFG_W'(1) : calib_samples_ff;
   assign count_next = calib_count_ff + 1'b1;

   // magnitude plus half the divisor gives round to nearest, ties away from zero
   assign sum_mag  = calib_sum_ff[CALIB_SUM_W-1] ? CALIB_SUM_W'(-calib_sum_ff)
                                                  : CALIB_SUM_W'(calib_sum_ff);
   assign dividend = sum_mag + CALIB_SUM_W'(n_eff >> 1);
   assign quo_s    = $signed(quotient);

   gyi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (n_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign tick_gap = tick_ff - last_tick_ff;
   assign gap_bad  = (tick_gap == '0) || (tick_gap > TICK_W'(max_dt_ff));

   assign yaw_sum   = SUM_W'(yaw_accum_ff) + SUM_W'(prod_ff);
   assign yaw_upper = yaw_sum[SUM_W-1:YAW_WIDTH-1];

   always_comb begin
      calib_samples_in = calib_samples_ff;
      max_dt_in        = max_dt_ff;
      default_dt_in    = default_dt_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_CALIB_SAMPLES: calib_samples_in = csr_wdata;
            CSR_MAX_DT:        max_dt_in        = csr_wdata;
            CSR_DEFAULT_DT:    default_dt_in    = csr_wdata;
            default:           ;
         endcase
      end
   end

   always_comb begin
      yaw_accum_in   = yaw_accum_ff;
      bias_in        = bias_ff;
      calib_sum_in   = calib_sum_ff;
      calib_count_in = calib_count_ff;
      last_tick_in   = last_tick_ff;
      is_ready_in    = is_ready_ff;
      dt_in          = dt_ff;
      delta_in       = delta_ff;
      prod_in        = prod_ff;
      if (cmd.restart) begin
         yaw_accum_in   = '0;
         bias_in        = '0;
         calib_sum_in   = '0;
         calib_count_in = '0;
         last_tick_in   = tick_ff;
         is_ready_in    = 1'b0;
      end
      if (cmd.calib_add) begin
         calib_sum_in   = calib_sum_ff + CALIB_SUM_W'(rate_ff);
         calib_count_in = count_next;
      end
      if (cmd.bias_load) begin
         bias_in      = calib_sum_ff[CALIB_SUM_W-1] ? BIAS_W'(-quo_s) : BIAS_W'(quo_s);
         last_tick_in = tick_ff;
         is_ready_in  = 1'b1;
      end
      if (cmd.step_prep) begin
         dt_in        = gap_bad ? default_dt_ff : tick_gap[CFG_W-1:0];
         delta_in     = DELTA_W'(rate_ff) - DELTA_W'(bias_ff);
         last_tick_in = tick_ff;
      end
      if (cmd.step_mul) begin
         prod_in = delta_ff * $signed({1'b0, dt_ff});
      end
      if (cmd.step_acc) begin
         // clamp when the bits above the yaw sign disagree with it
         if ((&yaw_upper) || !(|yaw_upper)) begin
            yaw_accum_in = yaw_sum[YAW_WIDTH-1:0];
         end else if (yaw_sum[SUM_W-1]) begin
            yaw_accum_in = {1'b1, {(YAW_WIDTH-1){1'b0}}};
         end else begin
            yaw_accum_in = {1'b0, {(YAW_WIDTH-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_samples_ff <= CALIB_SAMPLES_RESET;
         max_dt_ff        <= MAX_DT_RESET;
         default_dt_ff    <= DEFAULT_DT_RESET;
         yaw_accum_ff     <= '0;
         bias_ff          <= '0;
         calib_sum_ff     <= '0;
         calib_count_ff   <= '0;
         last_tick_ff     <= '0;
         is_ready_ff      <= 1'b0;
      end else begin
         calib_samples_ff <= calib_samples_in;
         max_dt_ff        <= max_dt_in;
         default_dt_ff    <= default_dt_in;
         yaw_accum_ff     <= yaw_accum_in;
         bias_ff          <= bias_in;
         calib_sum_ff     <= calib_sum_in;
         calib_count_ff   <= calib_count_in;
         last_tick_ff     <= last_tick_in;
         is_ready_ff      <= is_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         rate_ff <= req_gyro_rate;
         tick_ff <= req_tick_ms;
      end
      // yaw stays zero until calibration ends, so the state is the result
      if (cmd.out_load) begin
         rsp_yaw_ff   <= yaw_accum_ff;
         rsp_ready_ff <= is_ready_ff;
      end
   end

   always_comb begin
      status.op_restart = (op_ff == OP_RESTART);
      status.is_ready   = is_ready_ff;
      status.calib_last = (count_next >= n_eff);
      status.div_done   = div_done;
   end

   assign rsp_yaw_angle = rsp_yaw_ff;
   assign rsp_ready_res = rsp_ready_ff;

endmodule

// ===== rtl/gyro_yaw_integrator.sv =====
// ---------------------------------------------------------------------------
// gyro_yaw_integrator: gyro bias calibrated yaw integrator
// Controller, datapath and bias divider; one result per transaction.
// ---------------------------------------------------------------------------
// One transaction is worked on at a time and each gives exactly one result.
// A restart or an ordinary calibration sample goes through the execute and
// output states; an integration sample finds the tick gap in the execute
// state, then has states of its own for the rate times dt multiply and the
// saturating add. The last calibration sample runs the bias division on a
// restoring divider, one quotient bit per cycle over 26 bits. A finished
// result sits in an output register; a stalled result holds back the next
// result, not the acceptance of the transaction behind it. Yaw is in units
// of 1/16000 degree and stays zero while ready_res is low. Configuration
// registers (calib_samples, max_dt_ms, default_dt_ms) at indexes 0 to 2 are
// to be written only while the block is idle, which the block itself does
// not enforce; the user must see to it. Other indexes are ignored.
// ---------------------------------------------------------------------------
module gyro_yaw_integrator import gyi_pkg::*; #(
   parameter int YAW_WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic signed [RATE_W-1:0]    req_gyro_rate,
   input  logic [TICK_W-1:0]           req_tick_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [YAW_WIDTH-1:0] rsp_yaw_angle,
   output logic                        rsp_ready_res,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CFG_W-1:0]            csr_wdata
);

   gyi_cmd_type    cmd;
   gyi_status_type status;

   assign csr_ready = 1'b1;

   gyi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gyi_dp #(
      .YAW_WIDTH (YAW_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_opcode    (req_opcode),
      .req_gyro_rate (req_gyro_rate),
      .req_tick_ms   (req_tick_ms),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_yaw_angle (rsp_yaw_angle),
      .rsp_ready_res (rsp_ready_res)
   );

endmodule

// ===== rtl/gyi_checker.sv =====
// ---------------------------------------------------------------------------
// gyi_checker: port level checks for the gyro yaw integrator
// Watches the top level ports over time; bound to every instance.
// ---------------------------------------------------------------------------
module gyi_checker #(
   parameter int YAW_WIDTH = 48
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [YAW_WIDTH-1:0] rsp_yaw_angle,
   input logic                        rsp_ready_res
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_yaw_angle)
                                 && $stable(rsp_ready_res))
      else $error("held result changed");

   // no yaw reported before calibration has finished
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready_res |-> rsp_yaw_angle == '0)
      else $error("non-zero yaw while not ready");

   // one transaction in flight: the input closes right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transaction taken while busy");

   // reset leaves nothing to deliver and the input open
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state left over after reset");

endmodule

bind gyro_yaw_integrator gyi_checker #(.YAW_WIDTH(YAW_WIDTH)) u_checker (.*);

// ===== verif/tb_gyro_yaw_integrator.sv =====
// ---------------------------------------------------------------------------
// tb_gyro_yaw_integrator: self-checking testbench for the gyro yaw integrator
// A bias-calibrating yaw model predicts each result from the accepted
// samples and the register writes. Directed cases come first, then random
// calibrate-and-integrate runs, full-scale drifts and noise, under random
// request gaps and result stalls that a random run may turn off.
// ---------------------------------------------------------------------------
module tb_gyro_yaw_integrator;
   import gyi_pkg::*;

   localparam int YAW_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1200;
   localparam longint TIMEOUT_CYCLES = 1_000_000;

   typedef struct packed {
      logic signed [YAW_W-1:0] yaw_angle;
      logic                    ready_res;
   } yaw_result_type;

   class yaw_tracker_type;
      int unsigned n_calib;
      int unsigned n_max_dt;
      int unsigned n_default_dt;
      longint      yaw;
      int          bias;
      int          calib_sum;
      int unsigned calib_count;
      logic [TICK_W-1:0] last_tick;
      bit          is_ready;
      yaw_result_type expected_yaw_q[$];
      int          errors;
      int          checked;

      function new();
         n_calib      = 32'(CALIB_SAMPLES_RESET);
         n_max_dt     = 32'(MAX_DT_RESET);
         n_default_dt = 32'(DEFAULT_DT_RESET);
         yaw          = 0;
         bias         = 0;
         calib_sum    = 0;
         calib_count  = 0;
         last_tick    = '0;
         is_ready     = 1'b0;
         errors       = 0;
         checked      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         case (idx)
            CSR_CALIB_SAMPLES: n_calib = 32'(val);
            CSR_MAX_DT:        n_max_dt = 32'(val);
            CSR_DEFAULT_DT:    n_default_dt = 32'(val);
            default: ;
         endcase
      endfunction

      function void accept_sample(logic op, logic signed [RATE_W-1:0] rate,
                                  logic [TICK_W-1:0] tick);
         yaw_result_type res;
         int unsigned n, mag, q;
         logic [TICK_W-1:0] dt;
         longint step, hi, lo;
         res.yaw_angle = '0;
         res.ready_res = 1'b0;
         hi = (longint'(1) <<< (YAW_W - 1)) - 1;
         lo = -hi - 1;
         if (op == OP_RESTART) begin
            yaw         = 0;
            bias        = 0;
            calib_sum   = 0;
            calib_count = 0;
            last_tick   = tick;
            is_ready    = 1'b0;
         end else if (!is_ready) begin
            n = (n_calib == 0) ? 1 : n_calib;
            calib_sum   = calib_sum + int'(rate);
            calib_count = (calib_count + 1) % 1024;
            if (calib_count >= n) begin
               // rounded to nearest, ties away from zero
               mag  = (calib_sum < 0) ? -calib_sum : calib_sum;
               q    = (mag + n / 2) / n;
               bias = (calib_sum < 0) ? -int'(q) : int'(q);
               last_tick = tick;
               is_ready  = 1'b1;
               res.ready_res = 1'b1;
            end
         end else begin
            dt = tick - last_tick;
            last_tick = tick;
            if (dt == 0 || dt > n_max_dt) dt = n_default_dt;
            step = longint'(int'(rate) - bias) * longint'(dt);
            if (step > 0 && yaw > hi - step) yaw = hi;
            else if (step < 0 && yaw < lo - step) yaw = lo;
            else yaw = yaw + step;
            res.yaw_angle = yaw[YAW_W-1:0];
            res.ready_res = 1'b1;
         end
         expected_yaw_q.push_back(res);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch on result %0d: %s", checked, what);
      endtask

      task check_result(logic signed [YAW_W-1:0] got_yaw, logic got_ready);
         yaw_result_type want;
         checked++;
         if (expected_yaw_q.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = expected_yaw_q.pop_front();
            if (got_yaw !== want.yaw_angle)
               report_mismatch($sformatf("yaw_angle %0d, want %0d",
                                         got_yaw, want.yaw_angle));
            if (got_ready !== want.ready_res)
               report_mismatch($sformatf("ready_res %0b, want %0b",
                                         got_ready, want.ready_res));
         end
      endtask

      function int outstanding();
         return expected_yaw_q.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = OP_SAMPLE;
   logic signed [RATE_W-1:0]    req_gyro_rate = '0;
   logic [TICK_W-1:0]           req_tick_ms = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [YAW_W-1:0]     rsp_yaw_angle;
   logic                        rsp_ready_res;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CFG_W-1:0]            csr_wdata = '0;

   yaw_tracker_type   sb = new();
   int                sent_count = 0;
   logic [TICK_W-1:0] tick_now = '0;
   bit                gap_enable = 1'b1;
   bit                stall_enable = 1'b1;
   bit                long_hold_pending = 1'b0;

   gyro_yaw_integrator #(.YAW_WIDTH(YAW_W)) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_gyro_rate (req_gyro_rate),
      .req_tick_ms   (req_tick_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_yaw_angle (rsp_yaw_angle),
      .rsp_ready_res (rsp_ready_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_yaw_angle, rsp_ready_res);
   end

   function automatic int unsigned draw_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   // result side back-pressure, with one long hold when asked for
   initial begin : rsp_stall_gen
      int unsigned r, span;
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            span = 400;
         end else if (!stall_enable) begin
            rsp_stall <= 1'b0;
            span = 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_stall <= 1'b0;
               span = $urandom_range(1, 20);
            end else if (r < 95) begin
               rsp_stall <= 1'b1;
               span = $urandom_range(1, 4);
            end else begin
               rsp_stall <= 1'b1;
               span = $urandom_range(20, 60);
            end
         end
         repeat (span) @(posedge clock);
      end
   end

   function automatic logic signed [RATE_W-1:0] draw_rate(int centre, int spread);
      int unsigned r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 15) return RATE_W'($urandom_range(0, 65535));
      if (r < 22) return ($urandom_range(0, 1) != 0) ? RATE_W'(32767) : RATE_W'(-32768);
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return RATE_W'(v);
   endfunction

   function automatic logic [TICK_W-1:0] draw_gap();
      int unsigned r, m;
      m = (sb.n_max_dt == 0) ? 1 : sb.n_max_dt;
      r = $urandom_range(0, 99);
      if (r < 65) return $urandom_range(1, m);
      if (r < 73) return 0;
      if (r < 81) return m;
      if (r < 89) return m + 1 + $urandom_range(0, 50);
      return $urandom;
   endfunction

   task automatic send_item(input logic op, input logic signed [RATE_W-1:0] rate,
                            input logic [TICK_W-1:0] tick);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_gyro_rate <= rate;
      req_tick_ms   <= tick;
      do @(posedge clock); while (req_stall);
      sb.accept_sample(op, rate, tick);
      sent_count++;
      gap = gap_enable ? draw_idle() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_sample(input logic signed [RATE_W-1:0] rate,
                              input logic [TICK_W-1:0] gap);
      tick_now = tick_now + gap;
      send_item(OP_SAMPLE, rate, tick_now);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // a negative value leaves that register alone
   task automatic program_regs(input int calib, input int max_dt, input int dflt,
                               input int spare);
      logic [CSR_IDX_W-1:0] idx_list [4];
      int val_list [4];
      idx_list = '{CSR_CALIB_SAMPLES, CSR_MAX_DT, CSR_DEFAULT_DT, CSR_SPARE};
      val_list = '{calib, max_dt, dflt, spare};
      foreach (val_list[i]) begin
         if (val_list[i] >= 0) begin
            csr_valid <= 1'b1;
            csr_index <= idx_list[i];
            csr_wdata <= val_list[i][CFG_W-1:0];
            do @(posedge clock); while (!csr_ready);
            sb.write_register(idx_list[i], val_list[i][CFG_W-1:0]);
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic program_random();
      int calib, max_dt, dflt, spare;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) calib = 0;
      else if (r < 20) calib = 1;
      else if (r < 70) calib = $urandom_range(2, 8);
      else if (r < 92) calib = $urandom_range(9, 40);
      else calib = $urandom_range(41, 120);
      r = $urandom_range(0, 99);
      if (r < 10) max_dt = 0;
      else if (r < 20) max_dt = 1;
      else if (r < 30) max_dt = 1023;
      else if (r < 40) max_dt = 1000;
      else max_dt = $urandom_range(2, 600);
      r = $urandom_range(0, 99);
      if (r < 10) dflt = 0;
      else if (r < 20) dflt = 1;
      else if (r < 30) dflt = 1023;
      else dflt = $urandom_range(2, 500);
      if ($urandom_range(0, 9) < 3) calib = -1;
      if ($urandom_range(0, 9) < 3) max_dt = -1;
      if ($urandom_range(0, 9) < 3) dflt = -1;
      spare = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 1023)) : -1;
      program_regs(calib, max_dt, dflt, spare);
   endtask

   // usually a restart and a full calibration, then a stretch of integration
   task automatic run_calibrated_run(input bit force_restart);
      int centre, spread, n_cal;
      centre = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                           : int'($urandom_range(0, 8000)) - 4000;
      spread = $urandom_range(0, 300);
      if (force_restart || $urandom_range(0, 9) < 8) begin
         tick_now = tick_now + draw_gap();
         send_item(OP_RESTART, draw_rate(0, 32767), tick_now);
         n_cal = (sb.n_calib == 0) ? 1 : sb.n_calib;
         repeat (n_cal) send_sample(draw_rate(centre, spread), draw_gap());
      end
      repeat ($urandom_range(15, 60)) send_sample(draw_rate(centre, spread * 4), draw_gap());
   endtask

   // constant full-scale rate against an opposite bias gives the largest steps
   task automatic run_full_scale_drift();
      bit up;
      up = ($urandom_range(0, 1) != 0);
      send_item(OP_RESTART, draw_rate(0, 32767), tick_now);
      send_sample(up ? -32768 : 32767, draw_gap());
      repeat (40) send_sample(up ? 32767 : -32768, 0);
      repeat (5) send_sample(draw_rate(0, 32767), draw_gap());
   endtask

   task automatic run_noise();
      logic op;
      repeat (30) begin
         op = ($urandom_range(0, 99) < 15) ? OP_RESTART : OP_SAMPLE;
         tick_now = ($urandom_range(0, 1) != 0) ? $urandom : tick_now + draw_gap();
         send_item(op, RATE_W'($urandom_range(0, 65535)), tick_now);
      end
   endtask

   initial begin : main_seq
      int directed_total;
      int unsigned kind;
      bit first;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // bias of -2/3 rounds to -1, then wrap, zero gap, gap at and over the limit
      program_regs(3, 100, 7, 5);
      send_item(OP_RESTART, -32768, 32'hFFFF_FFE0);
      send_item(OP_SAMPLE, 32767, 32'h1234_5678);
      send_item(OP_SAMPLE, -32768, 32'hFFFF_FFFF);
      send_item(OP_SAMPLE, -1, 32'hFFFF_FFF0);
      send_item(OP_SAMPLE, 100, 32'h0000_0010);
      send_item(OP_SAMPLE, 100, 32'h0000_0010);
      send_item(OP_SAMPLE, -500, 32'h0000_0074);
      send_item(OP_SAMPLE, 32767, 32'h0000_00D9);
      send_item(OP_SAMPLE, -32768, 32'h0000_010B);
      send_item(OP_SAMPLE, 0, 32'hFFFF_FFFF);
      wait_all_results();

      // tie rounds away from zero; zero limit and zero default step
      program_regs(2, 0, 0, -1);
      send_item(OP_RESTART, 0, 32'd0);
      send_item(OP_SAMPLE, -1, 32'd1);
      send_item(OP_SAMPLE, -2, 32'd2);
      send_item(OP_SAMPLE, 1234, 32'd5);
      wait_all_results();

      // zero sample count behaves as one; full-scale step of 1000 ms
      program_regs(0, 1023, 1023, -1);
      send_item(OP_RESTART, 32767, 32'd100);
      send_item(OP_SAMPLE, 32767, 32'd200);
      send_item(OP_SAMPLE, -32768, 32'd1200);
      wait_all_results();

      // count lowered below the samples already taken mid-calibration
      program_regs(1023, 1, 1, 2);
      send_item(OP_RESTART, 0, 32'd50);
      send_item(OP_SAMPLE, 10, 32'd51);
      send_item(OP_SAMPLE, 20, 32'd52);
      send_item(OP_SAMPLE, 30, 32'd53);
      wait_all_results();
      program_regs(2, -1, -1, -1);
      send_item(OP_SAMPLE, 40, 32'd54);
      send_item(OP_SAMPLE, 60, 32'd55);
      tick_now = 32'd55;
      directed_total = sent_count;

      first = 1'b1;
      while (sent_count < directed_total + RANDOM_ITEMS) begin
         wait_all_results();
         kind = $urandom_range(0, 99);
         if (first) kind = 0;
         if (kind >= 75 && kind < 88) program_regs(1, -1, 1023, -1);
         else program_random();
         gap_enable   = ($urandom_range(0, 4) != 0);
         stall_enable = ($urandom_range(0, 4) != 0);
         if (first) begin
            // receiver holds off while the sender keeps offering
            gap_enable = 1'b0;
            long_hold_pending = 1'b1;
            while (long_hold_pending) @(posedge clock);
            first = 1'b0;
         end
         if (kind < 75) run_calibrated_run(kind == 0);
         else if (kind < 88) run_full_scale_drift();
         else run_noise();
      end

      wait_all_results();
      repeat (64) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("gyro_yaw_integrator test passed");
      end else begin
         $display("gyro_yaw_integrator test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 10);
      $display("gyro_yaw_integrator test failed");
      $finish;
   end

endmodule
